FILE: hw/rtl/dit_pkg.sv
// ----------------------------------------------------------------------------
// dit_pkg
// Shared codes and controller/datapath interface types for the interval table.
// ----------------------------------------------------------------------------
package dit_pkg;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVERLAP = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam int BOUND_W = 64;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CHECK  = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture transaction operands
        logic init;     // clear scan pointer and hit flag
        logic scan;     // step the entry scan
        logic finish;   // resolve status, commit insert, emit result
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic range_bad;  // low > high
        logic empty;      // no entries stored
        logic scan_done;  // hit found or last entry compared
    } dp_stat_t;

endpackage

FILE: hw/rtl/dit_ram.sv
// ----------------------------------------------------------------------------
// dit_ram
// Generic single-port write, single-port read RAM with registered read data.
// ----------------------------------------------------------------------------
module dit_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AddrW-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hw/rtl/dit_datapath.sv
// ----------------------------------------------------------------------------
// dit_datapath
// Operand registers, entry store, sequential overlap scan and result registers.
// ----------------------------------------------------------------------------
module dit_datapath
    import dit_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic               command,
    input  logic [BOUND_W-1:0] range_low,
    input  logic [BOUND_W-1:0] range_high,
    output logic               done,
    output logic               overlap_found,
    output logic [1:0]         status
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // transaction operands
    logic               cmd_reg;
    logic [BOUND_W-1:0] low_reg;
    logic [BOUND_W-1:0] high_reg;

    // fill count; entries below it are valid
    logic [CNT_W-1:0]   count_reg, count_next;

    // scan pipeline
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               pend_reg, pend_next;
    logic               last_reg, last_next;
    logic               found_reg, found_next;

    // result
    logic               done_reg, done_next;
    logic               ovl_reg, ovl_next;
    logic [1:0]         st_reg, st_next;

    logic                 wr_en;
    logic [2*BOUND_W-1:0] rd_data;
    logic [BOUND_W-1:0]   ent_low;
    logic [BOUND_W-1:0]   ent_high;
    logic                 hit;
    logic                 issue;
    logic                 full;

    dit_ram #(
        .WIDTH (2 * BOUND_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data ({high_reg, low_reg}),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign ent_low  = rd_data[BOUND_W-1:0];
    assign ent_high = rd_data[2*BOUND_W-1:BOUND_W];
    assign hit      = pend_reg && (ent_low <= high_reg) && (low_reg <= ent_high);
    assign issue    = cmd.scan && (rd_idx_reg < count_reg);
    assign full     = (count_reg == CAP_CNT);

    assign stat.range_bad = (low_reg > high_reg);
    assign stat.empty     = (count_reg == '0);
    assign stat.scan_done = pend_reg && (hit || last_reg);

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        pend_next   = pend_reg;
        last_next   = last_reg;
        found_next  = found_reg;
        count_next  = count_reg;
        done_next   = cmd.finish;
        ovl_next    = ovl_reg;
        st_next     = st_reg;
        wr_en       = 1'b0;

        if (cmd.init)
        begin
            rd_idx_next = '0;
            pend_next   = 1'b0;
            last_next   = 1'b0;
            found_next  = 1'b0;
        end
        else if (cmd.scan)
        begin
            pend_next = issue;
            last_next = (rd_idx_reg == count_reg - CNT_W'(1));
            if (issue)
            begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            end
            if (hit)
            begin
                found_next = 1'b1;
            end
        end

        if (cmd.finish)
        begin
            priority if (stat.range_bad)
            begin
                st_next  = ST_INVALID;
                ovl_next = 1'b0;
            end
            else if (cmd_reg == CMD_QUERY)
            begin
                st_next  = ST_OK;
                ovl_next = found_reg;
            end
            else if (found_reg)
            begin
                st_next  = ST_OVERLAP;
                ovl_next = 1'b1;
            end
            else if (full)
            begin
                st_next  = ST_FULL;
                ovl_next = 1'b0;
            end
            else
            begin
                st_next    = ST_OK;
                ovl_next   = 1'b0;
                wr_en      = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg  <= command;
            low_reg  <= range_low;
            high_reg <= range_high;
        end
        ovl_reg    <= ovl_next;
        st_reg     <= st_next;
        rd_idx_reg <= rd_idx_next;
        last_reg   <= last_next;
        found_reg  <= found_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    assign done          = done_reg;
    assign overlap_found = ovl_reg;
    assign status        = st_reg;

endmodule

FILE: hw/rtl/dit_ctrl.sv
// ----------------------------------------------------------------------------
// dit_ctrl
// Sequencer: operand capture, range check, entry scan, resolve.
// ----------------------------------------------------------------------------
module dit_ctrl
    import dit_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.init = 1'b1;
                if (stat.range_bad || stat.empty)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: hw/rtl/disjoint_interval_table.sv
// ----------------------------------------------------------------------------
// disjoint_interval_table
// Bounded table of disjoint closed intervals with insert and overlap query.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Each transaction
// gives exactly one result, shown for one cycle with done high; the receiver
// cannot hold it off, so it must sample on done. For an invalid range
// (low > high) or an empty table the range check goes straight to resolve;
// otherwise the scan of up to N stored entries lies between the two.
// The entry scan reads one stored interval per cycle from the single read port
// of the entry RAM and stops at the first overlap, so the fill level sets the
// cost. busy drops while the result is still on its way out, so a new
// transaction may be taken in the cycle done is high. No clearing pass follows
// reset: the fill count marks which RAM entries are valid, since entries fill
// in order and are never removed.
// ----------------------------------------------------------------------------
module disjoint_interval_table
    import dit_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    // request side
    input  logic               start,
    output logic               busy,
    input  logic               command,      // CMD_INSERT or CMD_QUERY
    input  logic [BOUND_W-1:0] range_low,    // inclusive
    input  logic [BOUND_W-1:0] range_high,   // inclusive
    // result side
    output logic               done,
    output logic               overlap_found,
    output logic [1:0]         status
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // sequencer
    dit_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (dp_cmd),
        .stat  (dp_stat)
    );

    // operands, entry RAM, compare and result registers
    dit_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (dp_cmd),
        .stat          (dp_stat),
        .command       (command),
        .range_low     (range_low),
        .range_high    (range_high),
        .done          (done),
        .overlap_found (overlap_found),
        .status        (status)
    );

endmodule

FILE: verif/disjoint_interval_table_test.sv
// ----------------------------------------------------------------------------
// disjoint_interval_table_test
// Self-checking bench for the disjoint interval table.
// A short table of directed transactions covers the empty table, the 64-bit
// bound extremes, touching and adjacent intervals and the invalid range code.
// A long random run then fills the table to capacity and keeps going on the
// full table. Each result is checked in order against a row's given result
// or else a behavioral model of the table that the bench keeps alongside.
// ----------------------------------------------------------------------------
module disjoint_interval_table_test
    import dit_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH       = 64;          // table capacity under test
    localparam logic [63:0] MAXV        = '1;          // all-ones bound
    localparam int          N_RANDOM    = 1530;        // random transactions
    localparam int          CALM_TAIL   = 150;         // last ones sent back to back
    localparam int          SETTLE      = DEPTH + 16;  // > worst result delay, a full-table scan
    localparam int          STALL_LIMIT = 2000;        // cycles with no handshake

    // One predicted result, tagged with the transaction number for reports.
    typedef struct packed {
        logic [31:0] seq;
        logic        found;
        logic [1:0]  stat;
    } verdict_t;

    // One row of the directed table. Where given is set, the expected result
    // is written in the row; otherwise the table model supplies it.
    typedef struct packed {
        logic        cmd;
        logic [63:0] lo;
        logic [63:0] hi;
        logic        given;
        logic        found;
        logic [1:0]  stat;
    } probe_t;

    localparam int N_PROBES = 22;

    probe_t probe_table [N_PROBES] = '{
        // empty table: nothing can hit, full-range query included
        '{CMD_QUERY,  64'h0, MAXV, 1'b1, 1'b0, ST_OK},
        // low > high for both commands, including the widest inversion
        '{CMD_INSERT, 64'h1, 64'h0, 1'b1, 1'b0, ST_INVALID},
        '{CMD_QUERY,  MAXV, 64'h0, 1'b1, 1'b0, ST_INVALID},
        // single points at both extremes of the bound range
        '{CMD_INSERT, 64'h0, 64'h0, 1'b1, 1'b0, ST_OK},
        '{CMD_INSERT, MAXV, MAXV, 1'b1, 1'b0, ST_OK},
        '{CMD_QUERY,  64'h0, 64'h0, 1'b1, 1'b1, ST_OK},
        '{CMD_INSERT, 64'h0, 64'h5, 1'b1, 1'b1, ST_OVERLAP},
        '{CMD_QUERY,  MAXV, MAXV, 1'b1, 1'b1, ST_OK},
        // adjacent intervals are disjoint, shared endpoints are not
        '{CMD_INSERT, 64'h1, 64'h100, 1'b0, 1'b0, ST_OK},
        '{CMD_INSERT, 64'h101, 64'h101, 1'b0, 1'b0, ST_OK},
        '{CMD_INSERT, 64'h100, 64'h200, 1'b0, 1'b0, ST_OK},
        '{CMD_QUERY,  64'h102, MAXV - 64'h1, 1'b0, 1'b0, ST_OK},
        '{CMD_QUERY,  MAXV - 64'h1, MAXV, 1'b0, 1'b0, ST_OK},
        '{CMD_INSERT, 64'hFFFF_FFFF_FFFF_F000, MAXV - 64'h1, 1'b0, 1'b0, ST_OK},
        // alternating bit patterns, inverted then as a point
        '{CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
          1'b1, 1'b0, ST_INVALID},
        '{CMD_INSERT, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555,
          1'b0, 1'b0, ST_OK},
        '{CMD_QUERY,  64'h5555_5555_5555_5554, 64'h5555_5555_5555_5554,
          1'b0, 1'b0, ST_OK},
        '{CMD_INSERT, 64'h5555_5555_5555_5556, 64'h5555_5555_5555_5FFF,
          1'b0, 1'b0, ST_OK},
        '{CMD_QUERY,  64'h5555_5555_5555_6000, 64'hFFFF_FFFF_FFFF_EFFF,
          1'b0, 1'b0, ST_OK},
        // insert into a free stretch, then the gap it leaves below and the full range
        '{CMD_INSERT, 64'h202, 64'h2FF, 1'b0, 1'b0, ST_OK},
        '{CMD_QUERY,  64'h102, 64'h201, 1'b0, 1'b0, ST_OK},
        '{CMD_QUERY,  64'h0, MAXV, 1'b0, 1'b0, ST_OK}
    };

    // ------------------------------------------------------------------------
    // Block under test; every input is known from time zero
    // ------------------------------------------------------------------------
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic        command     = CMD_INSERT;
    logic [63:0] range_low   = '0;
    logic [63:0] range_high  = '0;
    logic        busy;
    logic        done;
    logic        overlap_found;
    logic [1:0]  status;

    disjoint_interval_table #(
        .CAPACITY (DEPTH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .range_low     (range_low),
        .range_high    (range_high),
        .done          (done),
        .overlap_found (overlap_found),
        .status        (status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Table model: the set of stored intervals as the block should hold it
    // ------------------------------------------------------------------------
    logic [63:0] shadow_low  [DEPTH];
    logic [63:0] shadow_high [DEPTH];
    int          shadow_count = 0;

    verdict_t    verdict_q [$];      // results still owed by the block, oldest first

    int sent       = 0;              // transactions accepted
    int n_stored   = 0;
    int n_overlap  = 0;
    int n_full     = 0;
    int n_invalid  = 0;
    int n_query    = 0;
    int n_hit      = 0;
    int fault_count = 0;
    int calm_run   = 0;              // transactions left in a no-idle stretch

    // Resolves one transaction against the stored set and commits an insert.
    // Overlap is decided before fullness, so a full table still reports hits.
    function automatic verdict_t judge_interval(input logic cmd,
                                                input logic [63:0] lo,
                                                input logic [63:0] hi);
        verdict_t v;
        v.seq   = '0;
        v.found = 1'b0;
        v.stat  = ST_OK;
        if (lo > hi)
        begin
            v.stat = ST_INVALID;
            return v;
        end
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_low[i] <= hi && lo <= shadow_high[i])
                v.found = 1'b1;
        end
        if (cmd == CMD_INSERT)
        begin
            if (v.found)
                v.stat = ST_OVERLAP;
            else if (shadow_count >= DEPTH)
                v.stat = ST_FULL;
            else
            begin
                shadow_low[shadow_count]  = lo;
                shadow_high[shadow_count] = hi;
                shadow_count++;
            end
        end
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Random interval helpers
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // widths from a bit or two up to 2^48, so the bound space stays mostly free
    function automatic logic [63:0] rand_span();
        return rand64() >> $urandom_range(16, 63);
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s < a) ? MAXV : s;
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        return (b > a) ? 64'h0 : a - b;
    endfunction

    // Free stretch around point p; returns 0 when p lies inside a stored interval.
    function automatic bit find_gap(input logic [63:0] p,
                                    output logic [63:0] gap_lo,
                                    output logic [63:0] gap_hi);
        gap_lo = '0;
        gap_hi = MAXV;
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_low[i] <= p && p <= shadow_high[i])
                return 1'b0;
            if (shadow_high[i] < p && shadow_high[i] + 64'h1 > gap_lo)
                gap_lo = shadow_high[i] + 64'h1;
            if (shadow_low[i] > p && shadow_low[i] - 64'h1 < gap_hi)
                gap_hi = shadow_low[i] - 64'h1;
        end
        return 1'b1;
    endfunction

    // Interval placed against a random stored one. Shapes 0..4 overlap it
    // (meeting an endpoint, exact copy, covering, midpoint); 5 and 6 sit
    // just outside it and may still run into a neighbor.
    function automatic void near_entry(input int shape,
                                       output logic [63:0] lo,
                                       output logic [63:0] hi);
        int          e;
        int          k;
        logic [63:0] el;
        logic [63:0] eh;
        e  = $urandom_range(0, shadow_count - 1);
        el = shadow_low[e];
        eh = shadow_high[e];
        k  = shape;
        if (k == 5 && el == 64'h0)
            k = 0;
        if (k == 6 && eh == MAXV)
            k = 1;
        case (k)
            0:       begin lo = sat_sub(el, rand_span()); hi = el; end
            1:       begin lo = eh; hi = sat_add(eh, rand_span()); end
            2:       begin lo = el; hi = eh; end
            3:       begin lo = sat_sub(el, rand_span()); hi = sat_add(eh, rand_span()); end
            4:       begin lo = el + ((eh - el) >> 1); hi = lo; end
            5:       begin hi = el - 64'h1; lo = sat_sub(hi, rand_span()); end
            default: begin lo = eh + 64'h1; hi = sat_add(lo, rand_span()); end
        endcase
    endfunction

    // Mix: fresh inserts into free gaps (these fill the table over the run),
    // inserts against stored intervals, inverted ranges, raw noise, and
    // mostly queries aimed at or just beside stored intervals.
    function automatic void draw_transaction(output logic cmd,
                                             output logic [63:0] lo,
                                             output logic [63:0] hi);
        int          pick;
        bit          free;
        logic [63:0] p;
        logic [63:0] glo;
        logic [63:0] ghi;
        logic [63:0] t;
        pick = $urandom_range(0, 99);
        cmd  = CMD_QUERY;
        lo   = rand64();
        hi   = rand64();
        if (pick < 5)
        begin
            cmd  = CMD_INSERT;
            free = 1'b0;
            p    = '0;
            for (int tries = 0; tries < 8 && !free; tries++)
            begin
                p    = rand64();
                free = find_gap(p, glo, ghi);
            end
            lo = p;
            hi = p;
            if (free)
            begin
                lo = sat_sub(p, rand_span());
                hi = sat_add(p, rand_span());
                if (lo < glo)
                    lo = glo;
                if (hi > ghi)
                    hi = ghi;
            end
        end
        else if (pick < 20)
        begin
            cmd = CMD_INSERT;
            if (shadow_count > 0)
                near_entry($urandom_range(0, 6), lo, hi);
        end
        else if (pick < 24)
        begin
            // force low > high
            cmd = 1'($urandom_range(0, 1));
            if (lo < hi)
            begin
                t  = lo;
                lo = hi;
                hi = t;
            end
            if (lo == hi)
            begin
                if (lo == 64'h0)
                    lo = 64'h1;
                else
                    hi = lo - 64'h1;
            end
        end
        else if (pick < 30)
            cmd = 1'($urandom_range(0, 1));
        else if (shadow_count > 0 && $urandom_range(0, 9) < 8)
            near_entry($urandom_range(0, 6), lo, hi);
        else
            hi = sat_add(lo, rand_span());
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Holds start with the operands until a rising edge sees busy low, then
    // records what the block owes for this transaction. start stays high on
    // return so back-to-back transactions need no extra edge.
    task automatic issue(input logic cmd, input logic [63:0] lo, input logic [63:0] hi,
                         input logic given, input logic want_found,
                         input logic [1:0] want_stat);
        verdict_t v;
        start      <= 1'b1;
        command    <= cmd;
        range_low  <= lo;
        range_high <= hi;
        do
            @(posedge clk);
        while (busy);
        v = judge_interval(cmd, lo, hi);   // always run: it carries the table state
        if (given)
        begin
            v.found = want_found;
            v.stat  = want_stat;
        end
        v.seq = sent;
        verdict_q.push_back(v);
        sent++;
        case (v.stat)
            ST_OVERLAP: n_overlap++;
            ST_FULL:    n_full++;
            ST_INVALID: n_invalid++;
            default:    if (cmd == CMD_INSERT) n_stored++;
        endcase
        if (cmd == CMD_QUERY && v.stat != ST_INVALID)
        begin
            n_query++;
            if (v.found)
                n_hit++;
        end
    endtask

    // Sender idling: idle gaps of random length, broken by stretches with none.
    task automatic pause_sender(input bit calm);
        int gap;
        gap = 0;
        if (calm_run > 0)
            calm_run--;
        else if ($urandom_range(0, 19) == 0)
            calm_run = $urandom_range(10, 40);
        else if (!calm && $urandom_range(0, 99) < 35)
            gap = $urandom_range(1, 16);
        if (calm)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: done marks a one-cycle result that cannot be held off,
    // so it is taken at every rising edge that sees done high.
    // ------------------------------------------------------------------------
    verdict_t want;

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: unexpected result, nothing pending: expected none, got "
                         , $time, "overlap_found=%0b status=%0d", overlap_found, status);
                fault_count++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (overlap_found !== want.found)
                begin
                    $display("%0t: transaction %0d overlap_found expected %0b got %0b",
                             $time, want.seq, want.found, overlap_found);
                    fault_count++;
                end
                if (status !== want.stat)
                begin
                    $display("%0t: transaction %0d status expected %0d got %0d",
                             $time, want.seq, want.stat, status);
                    fault_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any handshake on either side restarts the count. The worst
    // honest gap is a full-table scan plus the longest sender burst.
    // ------------------------------------------------------------------------
    int stall_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, verdict_q.size());
            $display("disjoint_interval_table_test: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic        cmd;
        logic [63:0] lo;
        logic [63:0] hi;
        bit          calm;

        // reset once at the start, released on an edge
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int row = 0; row < N_PROBES; row++)
        begin
            issue(probe_table[row].cmd, probe_table[row].lo, probe_table[row].hi,
                  probe_table[row].given, probe_table[row].found, probe_table[row].stat);
            pause_sender(1'b0);
        end

        // random run; it keeps going until the table has filled up
        while (sent - N_PROBES < N_RANDOM || shadow_count < DEPTH)
        begin
            draw_transaction(cmd, lo, hi);
            issue(cmd, lo, hi, 1'b0, 1'b0, ST_OK);
            calm = (sent - N_PROBES >= N_RANDOM - CALM_TAIL);
            pause_sender(calm);
        end
        start <= 1'b0;

        // drain, then give a late or extra done time to show up
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Ran %0d transactions (%0d directed): %0d stored, %0d overlap rejects, ",
                 sent, N_PROBES, n_stored, n_overlap,
                 "%0d full rejects, %0d inverted ranges", n_full, n_invalid);
        $display("%0d queries with %0d hits; table ended with %0d of %0d entries",
                 n_query, n_hit, shadow_count, DEPTH);
        if (fault_count == 0 && verdict_q.size() == 0)
            $display("disjoint_interval_table_test: PASS");
        else
            $display("disjoint_interval_table_test: FAIL");
        $finish;
    end

endmodule
